FILE: hw/rtl/fda_pkg.sv
// Shared types, constants and helper functions for the float to decimal
// ASCII formatter. Depends on nothing; every other file uses it.
package fda_pkg;

  // Default count of digits after the decimal point
  localparam int AFTER_POINT_DIGITS_DEF = 3;

  // Field widths fixed by the single-precision format
  localparam int VALUE_W  = 32;
  localparam int MANT_W   = 24;
  localparam int CHAR_W   = 7;

  // Exponent field at or above this value is out of range (|x| >= 2^31)
  localparam logic [7:0] EXP_LIMIT = 8'd158;

  // Fixed-point working width and power-of-ten scale width (10^9 < 2^30)
  localparam int SW      = 64;
  localparam int SCALE_W = 30;
  localparam int PROD_W  = MANT_W + SCALE_W;
  localparam int SHAMT_W = 9;

  // Integer digits: integer part is below 2^31 < 10^10
  localparam int INT_DIGITS = 10;
  localparam int INT_CNT_W  = $clog2(INT_DIGITS + 1);

  // Shift-and-add-3 conversion: bits consumed per cycle and number of steps
  localparam int DABBLE_BITS = 4;
  localparam int BCD_STEPS   = SW / DABBLE_BITS;
  localparam int BCD_CNT_W   = $clog2(BCD_STEPS);

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ALIGN,
    ST_CONVERT,
    ST_ANALYZE,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FRAC,
    ST_ERR
  } state_t;

  typedef enum logic [2:0] {
    EMIT_SIGN,
    EMIT_INT,
    EMIT_POINT,
    EMIT_FRAC,
    EMIT_ERR
  } emit_kind_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;       // capture a new item and form the scaled product
    logic       align;      // shift the product into the fixed-point word
    logic       convert;    // one conversion step
    logic       analyze;    // find digit counts and align the digit strings
    logic       emit;       // load the output register with one character
    emit_kind_t kind;       // which character to load
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic err;          // value is out of range
    logic neg_nz;       // value is negative and nonzero
    logic int_last;     // one integer digit left to send
    logic keep_zero;    // no fraction digits survive trimming
    logic frac_last;    // one fraction digit left to send
  } status_t;

  // 10^d, evaluated at elaboration
  function automatic logic [SW-1:0] pow10(input int d);
    logic [SW-1:0] p;
    p = SW'(1);
    for (int i = 0; i < d; i++) begin
      p = p * SW'(10);
    end
    return p;
  endfunction

endpackage

FILE: hw/rtl/fda_ctrl.sv
// Sequencing state machine of the float to decimal ASCII formatter.
// Depends on fda_pkg; drives the datapath through cmd_t, reads status_t.
module fda_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fda_pkg::status_t status,
  output fda_pkg::cmd_t    cmd
);

  fda_pkg::state_t                    state, state_next;
  logic [fda_pkg::BCD_CNT_W-1:0]      step_cnt, step_cnt_next;
  logic                               out_valid_next;
  logic                               slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fda_pkg::ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fda_pkg::ST_IDLE:    if (in_valid) state_next = fda_pkg::ST_SCALE;
      fda_pkg::ST_SCALE:   state_next = status.err ? fda_pkg::ST_ERR : fda_pkg::ST_ALIGN;
      fda_pkg::ST_ALIGN:   state_next = fda_pkg::ST_CONVERT;
      fda_pkg::ST_CONVERT: begin
        if (step_cnt == fda_pkg::BCD_CNT_W'(fda_pkg::BCD_STEPS - 1)) begin
          state_next = fda_pkg::ST_ANALYZE;
        end
      end
      fda_pkg::ST_ANALYZE: state_next = status.neg_nz ? fda_pkg::ST_SIGN : fda_pkg::ST_INT;
      fda_pkg::ST_SIGN:    if (slot_free) state_next = fda_pkg::ST_INT;
      fda_pkg::ST_INT: begin
        if (slot_free && status.int_last) begin
          state_next = status.keep_zero ? fda_pkg::ST_IDLE : fda_pkg::ST_POINT;
        end
      end
      fda_pkg::ST_POINT:   if (slot_free) state_next = fda_pkg::ST_FRAC;
      fda_pkg::ST_FRAC:    if (slot_free && status.frac_last) state_next = fda_pkg::ST_IDLE;
      fda_pkg::ST_ERR:     if (slot_free) state_next = fda_pkg::ST_IDLE;
      default:             state_next = fda_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd           = '0;
    cmd.kind      = fda_pkg::EMIT_INT;
    in_ready      = 1'b0;
    step_cnt_next = step_cnt;
    unique case (state)
      fda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      fda_pkg::ST_SCALE: ;
      fda_pkg::ST_ALIGN: begin
        cmd.align     = 1'b1;
        step_cnt_next = '0;
      end
      fda_pkg::ST_CONVERT: begin
        cmd.convert   = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
      end
      fda_pkg::ST_ANALYZE: cmd.analyze = 1'b1;
      fda_pkg::ST_SIGN: begin
        cmd.emit = slot_free;
        cmd.kind = fda_pkg::EMIT_SIGN;
      end
      fda_pkg::ST_INT: begin
        cmd.emit = slot_free;
        cmd.kind = fda_pkg::EMIT_INT;
      end
      fda_pkg::ST_POINT: begin
        cmd.emit = slot_free;
        cmd.kind = fda_pkg::EMIT_POINT;
      end
      fda_pkg::ST_FRAC: begin
        cmd.emit = slot_free;
        cmd.kind = fda_pkg::EMIT_FRAC;
      end
      fda_pkg::ST_ERR: begin
        cmd.emit = slot_free;
        cmd.kind = fda_pkg::EMIT_ERR;
      end
      default: ;
    endcase
  end

  // Output register occupancy: set on load, clear when taken
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: hw/rtl/fda_dp.sv
// Datapath of the float to decimal ASCII formatter: scaling, fixed-point
// alignment, binary to BCD conversion, digit trimming and output register.
// Depends on fda_pkg; commanded by fda_ctrl.
module fda_dp #(
  parameter int AFTER_POINT_DIGITS = fda_pkg::AFTER_POINT_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic [fda_pkg::VALUE_W-1:0]    value_bits,
  input  logic                           round_half,
  input  fda_pkg::cmd_t                  cmd,
  output fda_pkg::status_t               status,
  output logic [fda_pkg::CHAR_W-1:0]     char_code,
  output logic                           last_char,
  output logic                           range_error
);

  localparam int D      = AFTER_POINT_DIGITS;
  localparam int NDIG   = fda_pkg::INT_DIGITS + D;
  localparam int BW     = 4 * NDIG;
  localparam int IW     = 4 * fda_pkg::INT_DIGITS;
  localparam int FW     = 4 * D;
  localparam int KW     = $clog2(D + 1);
  localparam int SW     = fda_pkg::SW;
  localparam logic [fda_pkg::SCALE_W-1:0] SCALE =
    fda_pkg::SCALE_W'(fda_pkg::pow10(D));

  logic [fda_pkg::PROD_W-1:0]          prod;
  logic signed [fda_pkg::SHAMT_W-1:0]  shamt;
  logic                                rnd;
  logic                                neg_nz;
  logic                                err;
  logic [SW-1:0]                       bin;
  logic [BW-1:0]                       bcd;
  logic [IW-1:0]                       int_sh;
  logic [fda_pkg::INT_CNT_W-1:0]       int_rem;
  logic [FW-1:0]                       frac_sh;
  logic [KW-1:0]                       frac_rem;
  logic                                keep_zero;

  logic [7:0]                          expf;
  logic [fda_pkg::MANT_W-1:0]          mant;
  logic signed [fda_pkg::SHAMT_W-1:0]  shamt_in;
  logic [SW-1:0]                       prod_ext;
  logic [SW-1:0]                       x;
  logic [fda_pkg::SHAMT_W-1:0]         rshift;
  logic [SW:0]                         x_rnd;
  logic [BW-1:0]                       bcd_step;
  logic [SW-1:0]                       bin_step;
  logic [IW-1:0]                       int_bcd;
  logic [FW-1:0]                       frac_bcd;
  logic [fda_pkg::INT_CNT_W-1:0]       int_len;
  logic [fda_pkg::INT_CNT_W-1:0]       int_pad;
  logic [KW-1:0]                       keep;

  // Decode the input word
  assign expf = value_bits[30:23];
  assign mant = (expf == 8'd0) ? {1'b0, value_bits[22:0]} : {1'b1, value_bits[22:0]};
  // Power of two applied to mant * 10^D * 2, i.e. exponent plus one
  assign shamt_in = (expf == 8'd0) ? -9'sd148
                                   : $signed({1'b0, expf}) - 9'sd149;

  // Align: x = floor(prod * 2^shamt), then S = (x + round) / 2
  assign prod_ext = {{(SW - fda_pkg::PROD_W){1'b0}}, prod};
  assign rshift   = fda_pkg::SHAMT_W'(-shamt);
  always_comb begin
    if (!shamt[fda_pkg::SHAMT_W-1]) begin
      x = prod_ext << shamt[3:0];
    end else if (rshift >= fda_pkg::SHAMT_W'(SW)) begin
      x = '0;
    end else begin
      x = prod_ext >> rshift[5:0];
    end
  end
  assign x_rnd = {1'b0, x} + {{SW{1'b0}}, rnd};

  // Shift-and-add-3, several bits per step
  always_comb begin
    bcd_step = bcd;
    bin_step = bin;
    for (int j = 0; j < fda_pkg::DABBLE_BITS; j++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_step[4*d +: 4] >= 4'd5) begin
          bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BW-2:0], bin_step[SW-1]};
      bin_step = {bin_step[SW-2:0], 1'b0};
    end
  end

  // Digit counts: highest nonzero integer digit, lowest nonzero fraction digit
  assign int_bcd  = bcd[BW-1:FW];
  assign frac_bcd = bcd[FW-1:0];
  always_comb begin
    int_len = fda_pkg::INT_CNT_W'(1);
    for (int i = 0; i < fda_pkg::INT_DIGITS; i++) begin
      if (int_bcd[4*i +: 4] != 4'd0) begin
        int_len = fda_pkg::INT_CNT_W'(i + 1);
      end
    end
    keep = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (frac_bcd[4*i +: 4] != 4'd0) begin
        keep = KW'(D - i);
      end
    end
  end
  assign int_pad = fda_pkg::INT_CNT_W'(fda_pkg::INT_DIGITS) - int_len;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod   <= fda_pkg::PROD_W'(mant) * fda_pkg::PROD_W'(SCALE);
      shamt  <= shamt_in;
      rnd    <= round_half;
      neg_nz <= value_bits[31] && (value_bits[30:0] != 31'd0);
      err    <= (expf >= fda_pkg::EXP_LIMIT);
    end
    if (cmd.align) begin
      bin <= x_rnd[SW:1];
      bcd <= '0;
    end else if (cmd.convert) begin
      bin <= bin_step;
      bcd <= bcd_step;
    end
    if (cmd.analyze) begin
      int_sh    <= int_bcd << {int_pad, 2'b00};
      int_rem   <= int_len;
      frac_sh   <= frac_bcd;
      frac_rem  <= keep;
      keep_zero <= (keep == '0);
    end
    if (cmd.emit) begin
      case (cmd.kind)
        fda_pkg::EMIT_SIGN: begin
          char_code   <= fda_pkg::CHAR_MINUS;
          last_char   <= 1'b0;
          range_error <= 1'b0;
        end
        fda_pkg::EMIT_INT: begin
          char_code   <= fda_pkg::CHAR_ZERO + fda_pkg::CHAR_W'(int_sh[IW-1 -: 4]);
          last_char   <= status.int_last && keep_zero;
          range_error <= 1'b0;
          int_sh      <= int_sh << 4;
          int_rem     <= int_rem - 1'b1;
        end
        fda_pkg::EMIT_POINT: begin
          char_code   <= fda_pkg::CHAR_POINT;
          last_char   <= 1'b0;
          range_error <= 1'b0;
        end
        fda_pkg::EMIT_FRAC: begin
          char_code   <= fda_pkg::CHAR_ZERO + fda_pkg::CHAR_W'(frac_sh[FW-1 -: 4]);
          last_char   <= status.frac_last;
          range_error <= 1'b0;
          frac_sh     <= frac_sh << 4;
          frac_rem    <= frac_rem - 1'b1;
        end
        default: begin
          char_code   <= fda_pkg::CHAR_NONE;
          last_char   <= 1'b1;
          range_error <= 1'b1;
        end
      endcase
    end
  end

  assign status.err       = err;
  assign status.neg_nz    = neg_nz;
  assign status.int_last  = (int_rem == fda_pkg::INT_CNT_W'(1));
  assign status.keep_zero = keep_zero;
  assign status.frac_last = (frac_rem == KW'(1));

endmodule

FILE: hw/rtl/float_to_decimal_ascii.sv
// Float to decimal ASCII formatter, top level.
// Depends on fda_pkg, fda_ctrl and fda_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: a single-precision bit
//   pattern plus a round flag. Output channel (out_valid/out_ready) returns
//   the decimal text one ASCII character per item, last_char set on the
//   final one. NaN, infinity or a magnitude of 2^31 or more yields a single
//   item with char_code 0 and both last_char and range_error set.
// Sequence:
//   After acceptance the value is scaled by 10^AFTER_POINT_DIGITS, aligned
//   into the 64-bit fixed-point word, converted to BCD by the shift-and-add-3
//   unit at four bits per cycle and trimmed. The first character follows the
//   trimming step and the rest follow at one per cycle while the receiver
//   keeps up. in_ready stays low until the last character of a number, or
//   the range error item, has been loaded into the output register.
//   in_ready is high only while no number is in progress; the next number is
//   taken while the last character still waits in the output register.
// Reset: rst (synchronous, active high) drops any number in progress and
//   empties the output register. A stalled receiver holds the current
//   character in place and pauses character generation.
module float_to_decimal_ascii #(
  parameter int AFTER_POINT_DIGITS = fda_pkg::AFTER_POINT_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fda_pkg::VALUE_W-1:0] value_bits,
  input  logic                        round_half,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fda_pkg::CHAR_W-1:0]  char_code,
  output logic                        last_char,
  output logic                        range_error
);

  fda_pkg::cmd_t    cmd;
  fda_pkg::status_t status;

  // Sequencer: owns the handshakes and the step counter
  fda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, digit storage and the output payload register
  fda_dp #(
    .AFTER_POINT_DIGITS (AFTER_POINT_DIGITS)
  ) u_dp (
    .clk         (clk),
    .value_bits  (value_bits),
    .round_half  (round_half),
    .cmd         (cmd),
    .status      (status),
    .char_code   (char_code),
    .last_char   (last_char),
    .range_error (range_error)
  );

  // One number at a time: no new item right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a number is in progress");

  // While idle, any pending character must close the previous number
  a_idle_only_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_ready && out_valid) |-> last_char)
    else $error("block idle before the last character was produced");

  // A range error is a lone, final, null character
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (last_char && char_code == fda_pkg::CHAR_NONE))
    else $error("malformed range error item");

  // Normal characters are a sign, a point or a decimal digit
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !range_error) |->
      (char_code == fda_pkg::CHAR_MINUS || char_code == fda_pkg::CHAR_POINT ||
       (char_code >= fda_pkg::CHAR_ZERO && char_code <= fda_pkg::CHAR_ZERO + 7'd9)))
    else $error("character outside the decimal set");

endmodule
